// ===== design/sssd_pkg.sv =====
// shared types, constants and segment lookup for the seven-segment scan driver
package sssd_pkg;

  localparam int POSITIONS = 4;
  localparam int MAX_LEVEL = 8;
  localparam int POS_W     = (POSITIONS > 2) ? 2 : 1;

  localparam int CHAR_W    = 7;
  localparam int SEG_W     = 7;
  localparam int LEVEL_W   = 4;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_SHIFT_L   = 3'd4;
  localparam logic [2:0] OP_SHIFT_R   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_M = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_P = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd6;

  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd250;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [1:0]        position;
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       digit_select;
    logic [SEG_W-1:0] segments;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_WRITE,
    CMD_CLEAR,
    CMD_CLEAR_ALL,
    CMD_SHIFT_L,
    CMD_SHIFT_R
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // character code to segment pattern, unknown codes are blank
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CHAR_W-1:0] code);
    logic [SEG_W-1:0] seg;
    seg = '0;
    unique case (code)
      7'd48:  seg = 7'h7E;
      7'd49:  seg = 7'h30;
      7'd50:  seg = 7'h6D;
      7'd51:  seg = 7'h79;
      7'd52:  seg = 7'h33;
      7'd53:  seg = 7'h5B;
      7'd54:  seg = 7'h5F;
      7'd55:  seg = 7'h70;
      7'd56:  seg = 7'h7F;
      7'd57:  seg = 7'h7B;
      7'd65:  seg = 7'h77;
      7'd66:  seg = 7'h1F;
      7'd67:  seg = 7'h4E;
      7'd68:  seg = 7'h3D;
      7'd69:  seg = 7'h4F;
      7'd70:  seg = 7'h47;
      7'd71:  seg = 7'h5E;
      7'd72:  seg = 7'h37;
      7'd73:  seg = 7'h06;
      7'd74:  seg = 7'h3C;
      7'd76:  seg = 7'h0E;
      7'd78:  seg = 7'h15;
      7'd79:  seg = 7'h1D;
      7'd80:  seg = 7'h67;
      7'd81:  seg = 7'h73;
      7'd82:  seg = 7'h05;
      7'd83:  seg = 7'h5B;
      7'd84:  seg = 7'h0F;
      7'd85:  seg = 7'h3E;
      7'd97:  seg = 7'h77;
      7'd98:  seg = 7'h1F;
      7'd99:  seg = 7'h0D;
      7'd100: seg = 7'h3D;
      7'd101: seg = 7'h4F;
      7'd102: seg = 7'h47;
      7'd103: seg = 7'h5E;
      7'd104: seg = 7'h17;
      7'd105: seg = 7'h06;
      7'd106: seg = 7'h3C;
      7'd108: seg = 7'h0E;
      7'd110: seg = 7'h15;
      7'd111: seg = 7'h1D;
      7'd112: seg = 7'h67;
      7'd113: seg = 7'h73;
      7'd114: seg = 7'h05;
      7'd115: seg = 7'h5B;
      7'd116: seg = 7'h0F;
      7'd117: seg = 7'h1C;
      7'd121: seg = 7'h6E;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// ===== design/sssd_front.sv =====
// front end: accepts input transactions and classifies them into commands
module sssd_front import sssd_pkg::*; (
  input  in_item_t      in_item_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic pos_ok;

  assign pos_ok     = ({30'd0, in_item_i.position} < POSITIONS);
  assign in_stall_o = q_status_i.full;

  always_comb begin
    cmd_o.pos       = in_item_i.position[POS_W-1:0];
    cmd_o.char_code = in_item_i.char_code;
    cmd_o.kind      = CMD_NOP;
    unique case (in_item_i.opcode)
      OP_TICK:      cmd_o.kind = CMD_TICK;
      OP_WRITE:     cmd_o.kind = pos_ok ? CMD_WRITE : CMD_NOP;
      OP_CLEAR:     cmd_o.kind = pos_ok ? CMD_CLEAR : CMD_NOP;
      OP_CLEAR_ALL: cmd_o.kind = CMD_CLEAR_ALL;
      OP_SHIFT_L:   cmd_o.kind = CMD_SHIFT_L;
      OP_SHIFT_R:   cmd_o.kind = CMD_SHIFT_R;
      default:      cmd_o.kind = CMD_NOP;
    endcase
  end

  // commands that do nothing are dropped here
  assign push_o = in_valid_i && !q_status_i.full && (cmd_o.kind != CMD_NOP);

endmodule

// ===== design/sssd_queue.sv =====
// two-entry command queue between front and back end
module sssd_queue import sssd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          cmd_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign status_o.not_empty = (count_q != 2'd0);
  assign status_o.full      = (count_q == 2'd2);
  assign head_o             = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/sssd_back.sv =====
// back end: character buffer, scan, blink and brightness logic, output register
module sssd_back import sssd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  cmd_t                 head_i,
  input  queue_status_t        q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  logic [LEVEL_W-1:0]  level_q   [POSITIONS];
  logic [LEVEL_W-1:0]  level_d   [POSITIONS];
  logic [3:0]          mask_q, mask_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                enable_q, enable_d;

  logic [CHAR_W-1:0]   buf_q     [POSITIONS];
  logic [CHAR_W-1:0]   buf_d     [POSITIONS];
  logic [POS_W-1:0]    scan_q, scan_d;
  logic [PERIOD_W-1:0] bcnt_q    [POSITIONS];
  logic [PERIOD_W-1:0] bcnt_d    [POSITIONS];
  logic                phase_q   [POSITIONS];
  logic                phase_d   [POSITIONS];
  logic [LEVEL_W-1:0]  bright_q  [POSITIONS];
  logic [LEVEL_W-1:0]  bright_d  [POSITIONS];
  logic                half_q, half_d;

  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                can_load;
  logic [POS_W-1:0]    np;
  logic                blink_on;
  logic                bright_on;
  logic                new_phase;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign np          = (scan_q == POS_W'(POSITIONS - 1)) ? '0 : scan_q + 1'b1;

  always_comb begin
    level_d     = level_q;
    mask_d      = mask_q;
    period_d    = period_q;
    enable_d    = enable_q;
    buf_d       = buf_q;
    scan_d      = scan_q;
    bcnt_d      = bcnt_q;
    phase_d     = phase_q;
    bright_d    = bright_q;
    half_d      = half_q;
    pop_o       = 1'b0;
    out_valid_d = can_load ? 1'b0 : out_valid_q;
    out_d       = out_q;
    blink_on    = 1'b1;
    bright_on   = 1'b1;
    new_phase   = phase_q[np];

    if (q_status_i.not_empty) begin
      unique case (head_i.kind)
        CMD_TICK: begin
          if (!enable_q) begin
            pop_o = 1'b1;
          end else if (can_load && !half_q) begin
            // blank the digit being left
            out_valid_d        = 1'b1;
            out_d.digit_select = 2'(scan_q);
            out_d.segments     = '0;
            out_d.last         = 1'b0;
            half_d             = 1'b1;
          end else if (can_load) begin
            if (mask_q[np]) begin
              if (bcnt_q[np] < period_q) begin
                bcnt_d[np] = bcnt_q[np] + 1'b1;
              end else begin
                bcnt_d[np] = '0;
                new_phase  = ~phase_q[np];
              end
              phase_d[np] = new_phase;
              blink_on    = !new_phase;
            end
            // brightness counter only runs on shows that blink let through
            if (blink_on && (level_q[np] < LEVEL_W'(MAX_LEVEL))) begin
              if (bright_q[np] == level_q[np]) begin
                bright_d[np] = '0;
                bright_on    = 1'b0;
              end else begin
                bright_d[np] = bright_q[np] + 1'b1;
              end
            end
            scan_d             = np;
            out_valid_d        = 1'b1;
            out_d.digit_select = 2'(np);
            out_d.segments     = (blink_on && bright_on) ? seg_lookup(buf_q[np]) : '0;
            out_d.last         = 1'b1;
            half_d             = 1'b0;
            pop_o              = 1'b1;
          end
        end
        CMD_WRITE: begin
          buf_d[head_i.pos] = head_i.char_code;
          pop_o             = 1'b1;
        end
        CMD_CLEAR: begin
          buf_d[head_i.pos] = '0;
          pop_o             = 1'b1;
        end
        CMD_CLEAR_ALL: begin
          for (int i = 0; i < POSITIONS; i++) begin
            buf_d[i] = '0;
          end
          pop_o = 1'b1;
        end
        CMD_SHIFT_L: begin
          for (int i = 0; i < POSITIONS - 1; i++) begin
            buf_d[i] = buf_q[i+1];
          end
          buf_d[POSITIONS-1] = head_i.char_code;
          pop_o              = 1'b1;
        end
        CMD_SHIFT_R: begin
          for (int i = 1; i < POSITIONS; i++) begin
            buf_d[i] = buf_q[i-1];
          end
          buf_d[0] = head_i.char_code;
          pop_o    = 1'b1;
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL0, CFG_LEVEL1, CFG_LEVEL2, CFG_LEVEL3: begin
          for (int i = 0; i < POSITIONS; i++) begin
            if (cfg_idx_i == CFG_IDX_W'(i)) begin
              level_d[i]  = cfg_wdata_i[LEVEL_W-1:0];
              bright_d[i] = '0;
            end
          end
        end
        CFG_BLINK_M: begin
          mask_d = cfg_wdata_i[3:0];
          for (int i = 0; i < POSITIONS; i++) begin
            bcnt_d[i]  = '0;
            phase_d[i] = 1'b0;
          end
        end
        CFG_BLINK_P: period_d = cfg_wdata_i[PERIOD_W-1:0];
        CFG_ENABLE:  enable_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POSITIONS; i++) begin
        level_q[i]  <= LEVEL_W'(MAX_LEVEL);
        buf_q[i]    <= '0;
        bcnt_q[i]   <= '0;
        phase_q[i]  <= 1'b0;
        bright_q[i] <= '0;
      end
      mask_q      <= '0;
      period_q    <= BLINK_PERIOD_RST;
      enable_q    <= 1'b1;
      scan_q      <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      buf_q       <= buf_d;
      bcnt_q      <= bcnt_d;
      phase_q     <= phase_d;
      bright_q    <= bright_d;
      mask_q      <= mask_d;
      period_q    <= period_d;
      enable_q    <= enable_d;
      scan_q      <= scan_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== design/seven_segment_scan_driver_core.sv =====
// top level of the multiplexed seven-segment scan driver
// A four-character buffer drives a multiplexed seven-segment display. Input
// transactions carry an opcode: tick, write char, clear position, clear all,
// shift left or shift right (unused opcodes are dropped). A tick with the
// display enabled gives two result transactions: the first blanks the digit
// that was selected (last low), the second moves the scan to the next digit
// and shows its character through the segment table (last high), unless blink
// or brightness blanks it. Buffer commands give no result; a tick gives its two
// results one after the other through a single output register and stays at the
// queue head until both are loaded, holding back later commands. A two-entry
// command queue sits between the front end and the back end; input is taken
// whenever that queue has room, also while a result waits on a stalled output.
// The user must write registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while the block is idle; the block does not enforce it: 0..3 brightness
// levels (writing clears that digit's brightness counter), 4 blink mask (clears
// all blink counters and phases), 5 blink period, 6 display enable.
module seven_segment_scan_driver_core import sssd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  logic          push;
  logic          pop;
  cmd_t          cmd_in;
  cmd_t          cmd_head;
  queue_status_t q_status;

  // classify incoming transactions
  sssd_front u_front (
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // decouples acceptance from execution
  sssd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .head_o   (cmd_head),
    .status_o (q_status)
  );

  // buffer, scan and dimming state plus the result register
  sssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (cmd_head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // the first result of a tick always blanks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> (out_item_o.segments == '0))
    else $error("first result of a tick is not blank");

  // the scan never selects a digit outside the display
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({30'd0, out_item_o.digit_select} < POSITIONS))
    else $error("digit select out of range");

  // nothing is taken from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_status.not_empty)
    else $error("command queue underflow");
`endif

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the seven-segment scan driver core
module tb_top import sssd_pkg::*; ();

  // spare opcodes and the register index past the end of the map
  localparam logic [2:0]           OP_SPARE6  = 3'd6;
  localparam logic [2:0]           OP_SPARE7  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int IDLE_PCT       = 27;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;

  // character ranges that hold the glyph tables, everything else is blank
  localparam int DIGIT_FIRST = 48;
  localparam int DIGIT_LAST  = 57;
  localparam int UPPER_FIRST = 65;
  localparam int UPPER_LAST  = 85;
  localparam int LOWER_FIRST = 97;
  localparam int LOWER_LAST  = 121;

  // glyphs in character order, first character in the top bits
  localparam logic [10*7-1:0] DIGIT_GLYPHS = {
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
  };
  localparam logic [21*7-1:0] UPPER_GLYPHS = {
    7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C,
    7'h00, 7'h0E, 7'h00, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F,
    7'h3E
  };
  localparam logic [25*7-1:0] LOWER_GLYPHS = {
    7'h77, 7'h1F, 7'h0D, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h17, 7'h06, 7'h3C,
    7'h00, 7'h0E, 7'h00, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F,
    7'h1C, 7'h00, 7'h00, 7'h00, 7'h6E
  };

  // one row of the directed table: a command and, for ticks whose outcome is
  // obvious, the two display results written out by hand
  typedef struct packed {
    in_item_t  cmd;
    bit        typed;
    out_item_t blank;
    out_item_t show;
  } vector_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  // mirror of the block: registers
  logic [LEVEL_W-1:0]  lvl_reg [POSITIONS];
  logic [3:0]          mask_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic                enable_reg;
  // mirror of the block: scan state
  logic [CHAR_W-1:0]   buf_chars [POSITIONS];
  logic [1:0]          scan_pos;
  logic [PERIOD_W-1:0] blink_cnt [POSITIONS];
  logic                blink_ph [POSITIONS];
  logic [LEVEL_W-1:0]  bright_cnt [POSITIONS];

  out_item_t   pending_scans_q [$];
  vector_t     directed_q [$];
  out_item_t   want_scan;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_run = 1'b0;

  seven_segment_scan_driver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // display predictor
  // ---------------------------------------------------------------------------

  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
    int c;
    c = code;
    if (c >= DIGIT_FIRST && c <= DIGIT_LAST) return DIGIT_GLYPHS[(DIGIT_LAST - c)*7 +: 7];
    if (c >= UPPER_FIRST && c <= UPPER_LAST) return UPPER_GLYPHS[(UPPER_LAST - c)*7 +: 7];
    if (c >= LOWER_FIRST && c <= LOWER_LAST) return LOWER_GLYPHS[(LOWER_LAST - c)*7 +: 7];
    return '0;
  endfunction

  // blink phase of a position, counts only where the mask bit is set
  function automatic bit blink_visible(input logic [1:0] p);
    if (!mask_reg[p]) return 1'b1;
    if (blink_cnt[p] < period_reg) begin
      blink_cnt[p] = blink_cnt[p] + 16'd1;
    end else begin
      blink_cnt[p] = '0;
      blink_ph[p]  = ~blink_ph[p];
    end
    return !blink_ph[p];
  endfunction

  // dimming: below full level one show in every level+1 goes dark
  function automatic bit bright_visible(input logic [1:0] p);
    if (lvl_reg[p] >= MAX_LEVEL) return 1'b1;
    if (bright_cnt[p] == lvl_reg[p]) begin
      bright_cnt[p] = '0;
      return 1'b0;
    end
    bright_cnt[p] = bright_cnt[p] + 4'd1;
    return 1'b1;
  endfunction

  // steps the mirror by one command, returns how many results it causes
  function automatic int predict_display(input in_item_t cmd, output out_item_t blank_res,
                                         output out_item_t show_res);
    logic [1:0] next_pos;
    bit         lit;
    blank_res = '0;
    show_res  = '0;
    case (cmd.opcode)
      OP_TICK: begin
        if (!enable_reg) return 0;
        blank_res.digit_select = scan_pos;
        next_pos = (scan_pos == 2'(POSITIONS - 1)) ? 2'd0 : scan_pos + 2'd1;
        scan_pos = next_pos;
        // dimming only advances when blink leaves the digit lit
        lit = blink_visible(next_pos);
        if (lit) lit = bright_visible(next_pos);
        show_res.digit_select = next_pos;
        show_res.segments     = lit ? glyph_of(buf_chars[next_pos]) : '0;
        show_res.last         = 1'b1;
        return 2;
      end
      OP_WRITE: if (cmd.position < POSITIONS) buf_chars[cmd.position] = cmd.char_code;
      OP_CLEAR: if (cmd.position < POSITIONS) buf_chars[cmd.position] = '0;
      OP_CLEAR_ALL: for (int p = 0; p < POSITIONS; p++) buf_chars[p] = '0;
      OP_SHIFT_L: begin
        for (int p = 0; p < POSITIONS - 1; p++) buf_chars[p] = buf_chars[p+1];
        buf_chars[POSITIONS-1] = cmd.char_code;
      end
      OP_SHIFT_R: begin
        for (int p = POSITIONS - 1; p > 0; p--) buf_chars[p] = buf_chars[p-1];
        buf_chars[0] = cmd.char_code;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // register write as the block sees it, with the counter clears it implies
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_LEVEL0, CFG_LEVEL1, CFG_LEVEL2, CFG_LEVEL3: begin
        lvl_reg[idx[1:0]]    = data[3:0];
        bright_cnt[idx[1:0]] = '0;
      end
      CFG_BLINK_M: begin
        mask_reg = data[3:0];
        for (int p = 0; p < POSITIONS; p++) begin
          blink_cnt[p] = '0;
          blink_ph[p]  = 1'b0;
        end
      end
      CFG_BLINK_P: period_reg = data;
      CFG_ENABLE:  enable_reg = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void cmd_row(input logic [2:0] op, input logic [1:0] pos,
                                  input logic [CHAR_W-1:0] ch);
    vector_t v;
    v = '0;
    v.cmd.opcode    = op;
    v.cmd.position  = pos;
    v.cmd.char_code = ch;
    directed_q.push_back(v);
  endfunction

  // tick with the blanked digit and the newly shown digit written out
  function automatic void tick_row(input logic [1:0] blank_sel, input logic [1:0] show_sel,
                                   input logic [SEG_W-1:0] show_seg);
    vector_t v;
    v = '0;
    v.cmd.opcode            = OP_TICK;
    v.typed                 = 1'b1;
    v.blank.digit_select    = blank_sel;
    v.show.digit_select     = show_sel;
    v.show.segments         = show_seg;
    v.show.last             = 1'b1;
    directed_q.push_back(v);
  endfunction

  // mostly ticks and buffer edits with printable characters, some noise
  function automatic in_item_t random_command();
    in_item_t c;
    int       pick;
    pick        = $urandom_range(99);
    c.position  = 2'($urandom_range(3));
    c.char_code = $urandom_range(1) ? 7'($urandom_range(LOWER_LAST, DIGIT_FIRST))
                                    : 7'($urandom_range(127));
    if (pick < 50)      c.opcode = OP_TICK;
    else if (pick < 65) c.opcode = OP_WRITE;
    else if (pick < 72) c.opcode = OP_CLEAR;
    else if (pick < 75) c.opcode = OP_CLEAR_ALL;
    else if (pick < 83) c.opcode = OP_SHIFT_L;
    else if (pick < 91) c.opcode = OP_SHIFT_R;
    else                c.opcode = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    return c;
  endfunction

  // offers one command, waits for the transaction, then predicts it
  task automatic issue_command(input in_item_t cmd, input bit typed,
                               input out_item_t t_blank, input out_item_t t_show);
    out_item_t r_blank;
    out_item_t r_show;
    int        n;
    if (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n = predict_display(cmd, r_blank, r_show);
    if (n == 2) begin
      pending_scans_q.push_back(typed ? t_blank : r_blank);
      pending_scans_q.push_back(typed ? t_show : r_show);
    end
  endtask

  // sender holds off until every result is out and the command queue drained
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_scans_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one setting per phase: the first ones pin the extremes, the rest are random
  task automatic load_setting(input int k);
    logic [15:0] levels;
    logic [15:0] mask_v;
    logic [15:0] period_v;
    logic        en_v;
    levels   = 16'($urandom);
    mask_v   = 16'($urandom_range(15));
    period_v = 16'($urandom_range(5));
    en_v     = ($urandom_range(9) != 0);
    case (k)
      // dark, every other, nearly full and full brightness, no blink
      0: begin levels = 16'h8710; mask_v = 16'h0; period_v = 16'h0; en_v = 1'b1; end
      // every digit blinks on each show, some levels above the maximum
      1: begin levels = 16'h298F; mask_v = 16'hF; period_v = 16'h0; en_v = 1'b1; end
      2: begin mask_v = 16'h5; period_v = 16'd3; en_v = 1'b1; end
      // display off, ticks must stay silent
      3: en_v = 1'b0;
      // longest blink period
      4: begin mask_v = 16'hF; period_v = 16'hFFFF; en_v = 1'b1; end
      default: ;
    endcase
    for (int i = 0; i < POSITIONS; i++)
      set_register(CFG_LEVEL0 + 3'(i), {12'($urandom), levels[4*i +: 4]});
    set_register(CFG_BLINK_M, {12'($urandom), mask_v[3:0]});
    set_register(CFG_BLINK_P, period_v);
    set_register(CFG_ENABLE, {15'($urandom), en_v});
    if (k == 3) set_register(CFG_UNUSED, 16'($urandom));
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_run && ($urandom_range(99) < IDLE_PCT);
  end

  // every result transaction is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scans_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual sel %0d seg %h last %0d",
                 $time, out_item_o.digit_select, out_item_o.segments, out_item_o.last);
        fail_count++;
      end else begin
        want_scan = pending_scans_q.pop_front();
        check_field("digit_select", 8'(want_scan.digit_select), 8'(out_item_o.digit_select));
        check_field("segments", 8'(want_scan.segments), 8'(out_item_o.segments));
        check_field("last", 8'(want_scan.last), 8'(out_item_o.last));
      end
    end
  end

  // cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("** seven_segment_scan_driver_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;

    // mirror starts from the reset state
    for (int p = 0; p < POSITIONS; p++) begin
      lvl_reg[p]    = LEVEL_W'(MAX_LEVEL);
      buf_chars[p]  = '0;
      blink_cnt[p]  = '0;
      blink_ph[p]   = 1'b0;
      bright_cnt[p] = '0;
    end
    mask_reg   = '0;
    period_reg = BLINK_PERIOD_RST;
    enable_reg = 1'b1;
    scan_pos   = '0;

    // directed table
    tick_row(2'd0, 2'd1, 7'h00);           // blank buffer after reset
    cmd_row(OP_WRITE, 2'd0, 7'd56);        // '8'
    cmd_row(OP_WRITE, 2'd1, 7'd65);        // 'A'
    cmd_row(OP_WRITE, 2'd2, 7'd121);       // 'y', top of the lit range
    cmd_row(OP_WRITE, 2'd3, 7'd127);       // highest code, no glyph
    tick_row(2'd1, 2'd2, 7'h6E);
    tick_row(2'd2, 2'd3, 7'h00);
    tick_row(2'd3, 2'd0, 7'h7F);           // scan wraps to the first digit
    tick_row(2'd0, 2'd1, 7'h77);
    cmd_row(OP_SHIFT_L, 2'd0, 7'd0);       // zero enters the last place
    cmd_row(OP_TICK, 2'd3, 7'd127);
    cmd_row(OP_SHIFT_R, 2'd1, 7'd85);      // 'U' enters the first place
    cmd_row(OP_TICK, 2'd0, 7'd0);
    cmd_row(OP_TICK, 2'd1, 7'd64);
    cmd_row(OP_CLEAR, 2'd0, 7'd127);
    cmd_row(OP_TICK, 2'd2, 7'd33);
    cmd_row(OP_TICK, 2'd3, 7'd94);
    cmd_row(OP_CLEAR_ALL, 2'd3, 7'd127);
    cmd_row(OP_SPARE6, 2'd3, 7'd127);      // unused opcodes are dropped
    cmd_row(OP_SPARE7, 2'd2, 7'd85);
    cmd_row(OP_WRITE, 2'd3, 7'd48);
    cmd_row(OP_TICK, 2'd1, 7'd1);
    cmd_row(OP_TICK, 2'd0, 7'd2);
    cmd_row(OP_SHIFT_L, 2'd2, 7'd127);
    cmd_row(OP_TICK, 2'd3, 7'd127);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i])
      issue_command(directed_q[i].cmd, directed_q[i].typed, directed_q[i].blank,
                    directed_q[i].show);

    // random phases, each behind a drain and a new register setting; one phase
    // runs with both sides at full rate
    for (int k = 0; k < PHASES; k++) begin
      settle_block();
      load_setting(k);
      quiet_run = (k == 5);
      repeat (PHASE_ITEMS) issue_command(random_command(), 1'b0, '0, '0);
    end
    quiet_run = 1'b0;

    // drain and give stray results a chance to show up
    settle_block();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("** seven_segment_scan_driver_core: PASSED **");
    else
      $display("** seven_segment_scan_driver_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sssd_pkg.sv
design/sssd_front.sv
design/sssd_queue.sv
design/sssd_back.sv
design/seven_segment_scan_driver_core.sv
bench/tb_top.sv
